FILE: rtl/rq_pkg.sv
// Shared types, constants and helpers for the int8 requantizer.
// Used by rq_cfg, rq_lane and the top level; no other dependencies.
package rq_pkg;

  localparam int ACC_W     = 32;
  localparam int OUT_W     = 8;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;
  localparam int STAGES    = 7;
  localparam int DEF_LANES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 2'd3;

  localparam logic [29:0] SCALE_RESET      = 30'h3F00_0000;
  localparam logic [7:0]  ZERO_RESET       = 8'h00;
  localparam logic [7:0]  CLAMP_LOW_RESET  = 8'h80;
  localparam logic [7:0]  CLAMP_HIGH_RESET = 8'h7F;

  // Settings as the lanes consume them: scale = ms * 2^(se-23), bounds already offset.
  typedef struct packed {
    logic [23:0]        ms;
    logic signed [8:0]  se;
    logic               scale_zero;
    logic signed [9:0]  fmin;
    logic signed [9:0]  fmax;
    logic signed [7:0]  zp;
  } rq_cfg_t;

  // Leading zero count; an all-zero word gives 31 and is flagged by the caller.
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] cnt;
    cnt = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) cnt = 5'(31 - i);
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/rq_cfg.sv
// Configuration registers of the requantizer and the derived lane settings.
// Depends on rq_pkg.
module rq_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rq_pkg::CFG_W-1:0]     cfg_data,
  output rq_pkg::rq_cfg_t              cfg_o
);
  import rq_pkg::*;

  logic [29:0] scale_bits;
  logic [7:0]  zero_offset;
  logic [7:0]  clamp_low;
  logic [7:0]  clamp_high;

  logic [6:0]        exp_f;
  logic [22:0]       frac_f;
  logic [4:0]        lzf;
  logic signed [9:0] zp_w;
  rq_cfg_t           cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_bits  <= SCALE_RESET;
      zero_offset <= ZERO_RESET;
      clamp_low   <= CLAMP_LOW_RESET;
      clamp_high  <= CLAMP_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:      scale_bits  <= cfg_data[29:0];
        REG_ZERO:       zero_offset <= cfg_data[7:0];
        REG_CLAMP_LOW:  clamp_low   <= cfg_data[7:0];
        REG_CLAMP_HIGH: clamp_high  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exp_f  = scale_bits[29:23];
    frac_f = scale_bits[22:0];
    lzf    = lzc32({frac_f, 9'b0});
    zp_w   = 10'(signed'(zero_offset));
    cfg_next.scale_zero = (exp_f == 7'd0) && (frac_f == 23'd0);
    if (exp_f != 7'd0) begin
      cfg_next.ms = {1'b1, frac_f};
      cfg_next.se = signed'({2'b0, exp_f}) - 9'sd127;
    end else begin
      // subnormal scale: bring the leading one up to bit 23
      cfg_next.ms = {frac_f, 1'b0} << lzf;
      cfg_next.se = -9'sd127 - signed'({4'b0, lzf});
    end
    cfg_next.fmin = 10'(signed'(clamp_low)) - zp_w;
    cfg_next.fmax = 10'(signed'(clamp_high)) - zp_w;
    cfg_next.zp   = signed'(zero_offset);
  end

  always_ff @(posedge clk) begin
    cfg_o <= cfg_next;
  end

endmodule

FILE: rtl/rq_lane.sv
// One requantizer lane: int32 -> fp32, scale multiply, clamp, round, offset.
// Seven register stages, each loaded by its own enable. Depends on rq_pkg.
module rq_lane (
  input  logic                             clk,
  input  logic [rq_pkg::STAGES-1:0]        en,
  input  logic [rq_pkg::ACC_W-1:0]         acc,
  input  rq_pkg::rq_cfg_t                  cfg,
  output logic [rq_pkg::OUT_W-1:0]         q_out
);
  import rq_pkg::*;

  // stage 1: input register
  logic [31:0] acc1;
  // stage 2: sign, magnitude, leading zeros
  logic        sgn2, zero2;
  logic [31:0] mag2;
  logic [4:0]  lz2;
  // stage 3: rounded 24-bit significand and exponent
  logic        sgn3, zero3;
  logic [23:0] m3;
  logic [5:0]  l3;
  // stage 4: raw product
  logic               sgn4, zero4;
  logic [47:0]        p4;
  logic signed [9:0]  t4;
  // stage 5: rounded product with shift
  logic        sgn5, small5, sat5;
  logic [24:0] r5;
  logic [3:0]  sh5;
  // stage 6: signed fixed point, 24 fraction bits
  logic signed [34:0] v6;
  // stage 7: result byte
  logic [7:0] q7;

  logic [31:0] mag_c;
  logic [31:0] norm_c;
  logic        up_c;
  logic [24:0] rnd_c;
  logic signed [9:0] e_c;
  logic [23:0] keep_c;
  logic        g_c, st_c, up5_c;
  logic [33:0] qm_c;
  logic signed [34:0] lo_c, hi_c;
  logic        below_c, above_c, over_c, rup_c;
  logic signed [10:0] fl_c, r_c, c_c, fmin_c, fmax_c, sum_c;

  always_ff @(posedge clk) begin
    if (en[0]) acc1 <= acc;
  end

  always_comb begin
    mag_c = acc1[31] ? (32'd0 - acc1) : acc1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sgn2  <= acc1[31];
      zero2 <= (mag_c == 32'd0);
      mag2  <= mag_c;
      lz2   <= lzc32(mag_c);
    end
  end

  always_comb begin
    norm_c = mag2 << lz2;
    up_c   = norm_c[7] & ((|norm_c[6:0]) | norm_c[8]);
    rnd_c  = {1'b0, norm_c[31:8]} + {24'd0, up_c};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sgn3  <= sgn2;
      zero3 <= zero2;
      m3    <= rnd_c[24] ? 24'h80_0000 : rnd_c[23:0];
      l3    <= 6'd31 - {1'b0, lz2} + {5'd0, rnd_c[24]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sgn4  <= sgn3;
      zero4 <= zero3 | cfg.scale_zero;
      p4    <= m3 * cfg.ms;
      t4    <= signed'({4'b0, l3}) + 10'(cfg.se);
    end
  end

  always_comb begin
    e_c    = t4 + signed'({9'b0, p4[47]});
    keep_c = p4[47] ? p4[47:24] : p4[46:23];
    g_c    = p4[47] ? p4[23] : p4[22];
    st_c   = p4[47] ? (|p4[22:0]) : (|p4[21:0]);
    up5_c  = g_c & (st_c | keep_c[0]);
  end

  // below one half the value acts as zero; from 512 up it clamps like 512
  always_ff @(posedge clk) begin
    if (en[4]) begin
      sgn5   <= sgn4;
      small5 <= zero4 | (e_c < -10'sd1);
      sat5   <= e_c > 10'sd8;
      r5     <= {1'b0, keep_c} + {24'd0, up5_c};
      sh5    <= 4'(e_c + 10'sd1);
    end
  end

  always_comb begin
    priority if (small5) qm_c = 34'd0;
    else if (sat5)       qm_c = 34'h2_0000_0000;
    else                 qm_c = {9'd0, r5} << sh5;
  end

  always_ff @(posedge clk) begin
    if (en[5]) v6 <= sgn5 ? -signed'({1'b0, qm_c}) : signed'({1'b0, qm_c});
  end

  always_comb begin
    fmin_c  = 11'(cfg.fmin);
    fmax_c  = 11'(cfg.fmax);
    lo_c    = signed'({fmin_c, 24'd0});
    hi_c    = signed'({fmax_c, 24'd0});
    below_c = v6 < lo_c;
    above_c = v6 > hi_c;
    fl_c    = v6[34:24];
    rup_c   = (v6[23:0] > 24'h80_0000) || ((v6[23:0] == 24'h80_0000) && fl_c[0]);
    r_c     = fl_c + signed'({10'd0, rup_c});
    // upper bound goes last, so reversed bounds give the high bound
    over_c  = below_c ? (fmin_c > fmax_c) : above_c;
    c_c     = over_c ? fmax_c : (below_c ? fmin_c : r_c);
    sum_c   = c_c + 11'(cfg.zp);
  end

  always_ff @(posedge clk) begin
    if (en[6]) q7 <= sum_c[7:0];
  end

  assign q_out = q7;

endmodule

FILE: rtl/int8_requantizer_fp32_core.sv
// Top level of the int8 requantizer: stream handshake, stage valids, lanes.
// Depends on rq_pkg, rq_cfg and rq_lane.
//
// Usage:
//   s_* carries one group of LANES signed 32-bit accumulators per transaction,
//   s_tlast marks the last group. m_* returns LANES signed bytes per
//   transaction with m_tlast copied from the input.
//   Each lane converts to single precision, scales, clamps to the configured
//   bounds less the zero point, rounds half to even and adds the zero point.
//   Seven register stages: the first loads at the edge that accepts a group,
//   and m_tvalid rises as the group enters the last. Throughput is one group
//   per cycle while m_tready is high, as every stage can then move each cycle.
//   Each stage takes new data whenever it is empty or the next stage moves,
//   so bubbles close up and a held result does not block earlier stages
//   until the pipe is full. When m_tready stays low the results hold and
//   s_tready drops once all stages are full.
//   The user must apply configuration writes (cfg_we/cfg_index/cfg_data) with
//   the pipe empty; the block does not enforce it. Reset (rst, synchronous)
//   empties the pipe, restores scale 0.5, zero point 0, bounds -128..127.
module int8_requantizer_fp32_core #(
  parameter int LANES = rq_pkg::DEF_LANES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [LANES*32-1:0]          s_tdata,   // acc_0 .. acc_(LANES-1), 32 bits each
  input  logic                         s_tlast,   // last_group
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [LANES*8-1:0]           m_tdata,   // out_0 .. out_(LANES-1), 8 bits each
  output logic                         m_tlast,   // last_group_out
  input  logic                         cfg_we,
  input  logic [rq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rq_pkg::CFG_W-1:0]     cfg_data
);
  import rq_pkg::*;

  rq_cfg_t             cfg;
  logic [STAGES:1]     vld;
  logic [STAGES:1]     lst;
  logic [STAGES+1:1]   rdy;

  rq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  always_comb begin
    rdy[STAGES+1] = m_tready;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) lst[1] <= s_tlast;
    for (int k = 2; k <= STAGES; k++) begin
      if (rdy[k]) lst[k] <= lst[k-1];
    end
  end

  genvar i;
  generate
    for (i = 0; i < LANES; i++) begin : g_lane
      rq_lane u_lane (
        .clk   (clk),
        .en    (rdy[STAGES:1]),
        .acc   (s_tdata[i*ACC_W +: ACC_W]),
        .cfg   (cfg),
        .q_out (m_tdata[i*OUT_W +: OUT_W])
      );
    end
  endgenerate

  assign s_tready = rdy[1];
  assign m_tvalid = vld[STAGES];
  assign m_tlast  = lst[STAGES];

endmodule
